/* rtl/prmf_pkg.sv */
// Shared constants and types for the push-relabel max-flow block.
// No dependencies; imported by prmf_active, push_relabel_max_flow and the testbench.
package prmf_pkg;

    localparam int NODE_BITS = 6;
    localparam int MAX_NODES = 1 << NODE_BITS;
    localparam int REG_BITS  = 7;
    localparam int CAP_BITS  = 16;
    localparam int RES_BITS  = CAP_BITS + 1;
    localparam int HGT_BITS  = 7;
    localparam int EXC_BITS  = 23;
    localparam int FLOW_BITS = 22;
    localparam int ADDR_BITS = 2 * NODE_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int CNT_BITS  = ADDR_BITS + 1;

    // Configuration register indexes
    localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [1:0] REG_SINK_NODE   = 2'd2;

    // Control of the active-node set
    typedef struct packed {
        logic                 clear_all;
        logic                 set_en;
        logic [NODE_BITS-1:0] set_idx;
        logic                 clr_en;
        logic [NODE_BITS-1:0] clr_idx;
    } act_ctrl_t;

    typedef struct packed {
        logic                 any;
        logic [NODE_BITS-1:0] first;
    } act_stat_t;

endpackage

/* rtl/prmf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module prmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/prmf_active.sv */
// Active-node set: one flag per node, lowest-numbered active node reported.
// Depends on prmf_pkg.
module prmf_active (
    input  logic                clk,
    input  logic                rst_n,
    input  prmf_pkg::act_ctrl_t ctrl,
    output prmf_pkg::act_stat_t stat
);
    import prmf_pkg::*;

    logic [MAX_NODES-1:0] act_reg;
    logic [MAX_NODES-1:0] act_next;

    // set/clear updates
    always_comb
    begin
        act_next = act_reg;
        if (ctrl.clr_en)
        begin
            act_next[ctrl.clr_idx] = 1'b0;
        end
        if (ctrl.set_en)
        begin
            act_next[ctrl.set_idx] = 1'b1;
        end
        if (ctrl.clear_all)
        begin
            act_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    // priority encoder, lowest index wins
    always_comb
    begin
        stat.any   = |act_reg;
        stat.first = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (act_reg[i])
            begin
                stat.first = NODE_BITS'(i);
            end
        end
    end

endmodule

/* rtl/push_relabel_max_flow.sv */
// Push-relabel max-flow engine: edge loading, residual copy, discharge sequencer.
// Depends on prmf_pkg, prmf_ram, prmf_active.
//
// Edges are taken one item per cycle, only while idle, into a 4096-entry capacity
// memory. The item marked last starts the computation: for a valid source and sink,
// a copy of capacities into the residual memory, then the source saturation and
// discharge sequence, all through the single read port of the residual memory;
// otherwise the answer is zero. Total time is data dependent. After the answer is
// handed over, the capacity memory is zeroed in a clearing pass (also run after
// reset), during which no item is taken; configuration writes are taken at any time.
module push_relabel_max_flow (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [prmf_pkg::REG_BITS-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [prmf_pkg::REG_BITS-1:0]      from_node,
    input  logic [prmf_pkg::REG_BITS-1:0]      to_node,
    input  logic [prmf_pkg::CAP_BITS-1:0]      edge_capacity,
    input  logic                               last_edge,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [prmf_pkg::FLOW_BITS-1:0]     max_flow
);
    import prmf_pkg::*;

    typedef enum logic [17:0] {
        S_CLR   = 18'h00001,
        S_IDLE  = 18'h00002,
        S_CHECK = 18'h00004,
        S_COPY  = 18'h00008,
        S_PRD   = 18'h00010,
        S_PCHK  = 18'h00020,
        S_PWR1  = 18'h00040,
        S_PWR2  = 18'h00080,
        S_LOAD  = 18'h00100,
        S_LOAD2 = 18'h00200,
        S_RRD   = 18'h00400,
        S_RCHK  = 18'h00800,
        S_RFIN  = 18'h01000,
        S_FIN   = 18'h02000,
        S_SEL   = 18'h04000,
        S_TRD   = 18'h08000,
        S_TLAT  = 18'h10000,
        S_DONE  = 18'h20000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [NODE_BITS-1:0]   u_reg, u_next;
    logic [REG_BITS-1:0]    v_reg, v_next;
    logic [EXC_BITS-1:0]    cur_ex_reg, cur_ex_next;
    logic [HGT_BITS-1:0]    hu_reg, hu_next;
    logic [RES_BITS-1:0]    fwd_reg, fwd_next;
    logic [EXC_BITS-1:0]    exv_reg, exv_next;
    logic [RES_BITS-1:0]    amt_reg, amt_next;
    logic [HGT_BITS-1:0]    low_reg, low_next;
    logic                   found_reg, found_next;
    logic                   sat_reg, sat_next;
    logic                   cpw_reg, cpw_next;
    logic [ADDR_BITS-1:0]   cpa_reg, cpa_next;
    logic [FLOW_BITS-1:0]   result_reg, result_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FLOW_BITS-1:0]   max_flow_reg, max_flow_next;
    logic [REG_BITS-1:0]    node_count_reg, node_count_next;
    logic [REG_BITS-1:0]    source_reg, source_next;
    logic [REG_BITS-1:0]    sink_reg, sink_next;

    // memory ports
    logic                   cap_we;
    logic [ADDR_BITS-1:0]   cap_waddr, cap_raddr;
    logic [CAP_BITS-1:0]    cap_wdata, cap_rdata;
    logic                   res_we;
    logic [ADDR_BITS-1:0]   res_waddr, res_raddr;
    logic [RES_BITS-1:0]    res_wdata, res_rdata;
    logic                   hgt_we;
    logic [NODE_BITS-1:0]   hgt_waddr, hgt_raddr;
    logic [HGT_BITS-1:0]    hgt_wdata, hgt_rdata;
    logic                   exc_we;
    logic [NODE_BITS-1:0]   exc_waddr, exc_raddr;
    logic [EXC_BITS-1:0]    exc_wdata, exc_rdata;

    act_ctrl_t              act_ctrl;
    act_stat_t              act_stat;

    logic [REG_BITS-1:0]    n_eff;
    logic [NODE_BITS-1:0]   s_idx, t_idx, v_idx;
    logic                   st_ok;
    logic                   in_acc;
    logic                   edge_ok;
    logic [REG_BITS-1:0]    from_m1, to_m1;

    prmf_ram #(.WIDTH(CAP_BITS), .DEPTH(MEM_DEPTH)) u_cap_ram (
        .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(cap_raddr), .rdata(cap_rdata)
    );

    prmf_ram #(.WIDTH(RES_BITS), .DEPTH(MEM_DEPTH)) u_res_ram (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(res_raddr), .rdata(res_rdata)
    );

    prmf_ram #(.WIDTH(HGT_BITS), .DEPTH(MAX_NODES)) u_hgt_ram (
        .clk(clk), .we(hgt_we), .waddr(hgt_waddr), .wdata(hgt_wdata),
        .raddr(hgt_raddr), .rdata(hgt_rdata)
    );

    prmf_ram #(.WIDTH(EXC_BITS), .DEPTH(MAX_NODES)) u_exc_ram (
        .clk(clk), .we(exc_we), .waddr(exc_waddr), .wdata(exc_wdata),
        .raddr(exc_raddr), .rdata(exc_rdata)
    );

    prmf_active u_active (
        .clk(clk), .rst_n(rst_n), .ctrl(act_ctrl), .stat(act_stat)
    );

    // effective node count, source and sink checks
    always_comb
    begin
        if (node_count_reg < REG_BITS'(2))
        begin
            n_eff = REG_BITS'(2);
        end
        else if (node_count_reg > REG_BITS'(MAX_NODES))
        begin
            n_eff = REG_BITS'(MAX_NODES);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    assign st_ok = (source_reg != '0) && (source_reg <= n_eff) &&
                   (sink_reg != '0) && (sink_reg <= n_eff) && (source_reg != sink_reg);
    assign s_idx = NODE_BITS'(source_reg - REG_BITS'(1));
    assign t_idx = NODE_BITS'(sink_reg - REG_BITS'(1));
    assign v_idx = v_reg[NODE_BITS-1:0];

    // input edge decode
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign from_m1  = from_node - REG_BITS'(1);
    assign to_m1    = to_node - REG_BITS'(1);
    assign edge_ok  = (from_node != '0) && (from_node <= REG_BITS'(MAX_NODES)) &&
                      (to_node != '0) && (to_node <= REG_BITS'(MAX_NODES));

    // memory address and write muxing
    always_comb
    begin
        cap_we    = 1'b0;
        cap_waddr = {from_m1[NODE_BITS-1:0], to_m1[NODE_BITS-1:0]};
        cap_wdata = edge_capacity;
        cap_raddr = cnt_reg[ADDR_BITS-1:0];
        res_we    = 1'b0;
        res_waddr = {u_reg, v_idx};
        res_wdata = fwd_reg - amt_reg;
        res_raddr = (state_reg == S_PCHK) ? {v_idx, u_reg} : {u_reg, v_idx};
        hgt_we    = 1'b0;
        hgt_waddr = u_reg;
        hgt_wdata = low_reg + HGT_BITS'(1);
        hgt_raddr = (state_reg == S_LOAD) ? u_reg : v_idx;
        exc_we    = 1'b0;
        exc_waddr = v_idx;
        exc_wdata = exv_reg + EXC_BITS'(amt_reg);
        exc_raddr = v_idx;
        if (state_reg == S_LOAD)
        begin
            exc_raddr = u_reg;
        end
        else if (state_reg == S_TRD)
        begin
            exc_raddr = t_idx;
        end

        case (state_reg)
            S_IDLE:
            begin
                cap_we = in_acc && edge_ok;
            end
            S_CLR:
            begin
                cap_we    = 1'b1;
                cap_waddr = cnt_reg[ADDR_BITS-1:0];
                cap_wdata = '0;
            end
            S_COPY:
            begin
                res_we    = cpw_reg;
                res_waddr = cpa_reg;
                res_wdata = RES_BITS'(cap_rdata);
                // node tables initialized over the first row of the sweep
                hgt_we    = (cnt_reg < CNT_BITS'(MAX_NODES));
                hgt_waddr = cnt_reg[NODE_BITS-1:0];
                hgt_wdata = (cnt_reg[NODE_BITS-1:0] == s_idx) ? n_eff : '0;
                exc_we    = hgt_we;
                exc_waddr = cnt_reg[NODE_BITS-1:0];
                exc_wdata = '0;
            end
            S_PWR1:
            begin
                // reverse edge gains the pushed amount
                res_we    = 1'b1;
                res_waddr = {v_idx, u_reg};
                res_wdata = res_rdata + amt_reg;
                exc_we    = 1'b1;
            end
            S_PWR2:
            begin
                res_we = 1'b1;
            end
            S_RFIN:
            begin
                hgt_we    = found_reg;
                exc_we    = 1'b1;
                exc_waddr = u_reg;
                exc_wdata = cur_ex_reg;
            end
            S_FIN:
            begin
                exc_we    = 1'b1;
                exc_waddr = u_reg;
                exc_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    // active set control
    always_comb
    begin
        act_ctrl.clear_all = (state_reg == S_CHECK);
        act_ctrl.set_en    = (state_reg == S_PWR1) && (amt_reg != '0) &&
                             (v_idx != s_idx) && (v_idx != t_idx);
        act_ctrl.set_idx   = v_idx;
        act_ctrl.clr_en    = (state_reg == S_FIN) || ((state_reg == S_RFIN) && !found_reg);
        act_ctrl.clr_idx   = u_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        cur_ex_next     = cur_ex_reg;
        hu_next         = hu_reg;
        fwd_next        = fwd_reg;
        exv_next        = exv_reg;
        amt_next        = amt_reg;
        low_next        = low_reg;
        found_next      = found_reg;
        sat_next        = sat_reg;
        cpw_next        = 1'b0;
        cpa_next        = cpa_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && out_stall;
        max_flow_next   = max_flow_reg;
        node_count_next = node_count_reg;
        source_next     = source_reg;
        sink_next       = sink_reg;

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NODE_COUNT:  node_count_next = cfg_data;
                REG_SOURCE_NODE: source_next     = cfg_data;
                REG_SINK_NODE:   sink_next       = cfg_data;
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_CLR:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && last_edge)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (st_ok)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    result_next = '0;
                    state_next  = S_DONE;
                end
            end
            S_COPY:
            begin
                // read capacity at cnt, write residual in the following cycle
                if (cnt_reg < CNT_BITS'(MEM_DEPTH))
                begin
                    cpw_next = 1'b1;
                    cpa_next = cnt_reg[ADDR_BITS-1:0];
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
                else
                begin
                    u_next      = s_idx;
                    v_next      = '0;
                    sat_next    = 1'b1;
                    cur_ex_next = '1;
                    state_next  = S_PRD;
                end
            end
            S_PRD:
            begin
                if (!sat_reg && (cur_ex_reg == '0))
                begin
                    state_next = S_FIN;
                end
                else if (v_reg == n_eff)
                begin
                    v_next     = '0;
                    found_next = 1'b0;
                    state_next = sat_reg ? S_SEL : S_RRD;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                fwd_next = res_rdata;
                exv_next = exc_rdata;
                if (EXC_BITS'(res_rdata) < cur_ex_reg)
                begin
                    amt_next = res_rdata;
                end
                else
                begin
                    amt_next = cur_ex_reg[RES_BITS-1:0];
                end
                // admissible: residual left and strictly downhill, or any residual edge while saturating the source
                if ((v_idx != u_reg) && (res_rdata != '0) &&
                    (sat_reg || (hu_reg > hgt_rdata)))
                begin
                    state_next = S_PWR1;
                end
                else
                begin
                    v_next     = v_reg + REG_BITS'(1);
                    state_next = S_PRD;
                end
            end
            S_PWR1:
            begin
                cur_ex_next = cur_ex_reg - EXC_BITS'(amt_reg);
                state_next  = S_PWR2;
            end
            S_PWR2:
            begin
                v_next     = v_reg + REG_BITS'(1);
                state_next = S_PRD;
            end
            S_SEL:
            begin
                if (act_stat.any)
                begin
                    u_next     = act_stat.first;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_TRD;
                end
            end
            S_LOAD:
            begin
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                cur_ex_next = exc_rdata;
                hu_next     = hgt_rdata;
                v_next      = '0;
                sat_next    = 1'b0;
                state_next  = S_PRD;
            end
            S_RRD:
            begin
                state_next = (v_reg == n_eff) ? S_RFIN : S_RCHK;
            end
            S_RCHK:
            begin
                // lowest neighbor height over residual edges
                if ((v_idx != u_reg) && (res_rdata != '0) &&
                    (!found_reg || (hgt_rdata < low_reg)))
                begin
                    low_next   = hgt_rdata;
                    found_next = 1'b1;
                end
                v_next     = v_reg + REG_BITS'(1);
                state_next = S_RRD;
            end
            S_RFIN:
            begin
                state_next = S_SEL;
            end
            S_FIN:
            begin
                state_next = S_SEL;
            end
            S_TRD:
            begin
                state_next = S_TLAT;
            end
            S_TLAT:
            begin
                result_next = exc_rdata[FLOW_BITS-1:0];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    max_flow_next  = result_reg;
                    cnt_next       = '0;
                    state_next     = S_CLR;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cnt_reg        <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            cur_ex_reg     <= '0;
            hu_reg         <= '0;
            fwd_reg        <= '0;
            exv_reg        <= '0;
            amt_reg        <= '0;
            low_reg        <= '0;
            found_reg      <= 1'b0;
            sat_reg        <= 1'b0;
            cpw_reg        <= 1'b0;
            cpa_reg        <= '0;
            result_reg     <= '0;
            out_valid_reg  <= 1'b0;
            max_flow_reg   <= '0;
            node_count_reg <= REG_BITS'(MAX_NODES);
            source_reg     <= REG_BITS'(1);
            sink_reg       <= REG_BITS'(MAX_NODES);
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            u_reg          <= u_next;
            v_reg          <= v_next;
            cur_ex_reg     <= cur_ex_next;
            hu_reg         <= hu_next;
            fwd_reg        <= fwd_next;
            exv_reg        <= exv_next;
            amt_reg        <= amt_next;
            low_reg        <= low_next;
            found_reg      <= found_next;
            sat_reg        <= sat_next;
            cpw_reg        <= cpw_next;
            cpa_reg        <= cpa_next;
            result_reg     <= result_next;
            out_valid_reg  <= out_valid_next;
            max_flow_reg   <= max_flow_next;
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            sink_reg       <= sink_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_flow  = max_flow_reg;

endmodule

/* sim/push_relabel_max_flow_tb.sv */
// Self-checking testbench for push_relabel_max_flow: edge items in, max-flow answers out.
// Depends on prmf_pkg and the push_relabel_max_flow RTL; a push-relabel predictor
// computes the expected answer for every graph.
`timescale 1ns / 100ps

module push_relabel_max_flow_tb;

    import prmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000000;
    localparam int DRAIN_CYCLES   = 4400;   // clearing pass plus margin

    typedef struct {
        logic [REG_BITS-1:0] tail;
        logic [REG_BITS-1:0] head;
        logic [CAP_BITS-1:0] cap;
        logic                last;
    } edge_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [REG_BITS-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [REG_BITS-1:0]  from_node;
    logic [REG_BITS-1:0]  to_node;
    logic [CAP_BITS-1:0]  edge_capacity;
    logic                 last_edge;
    logic                 out_valid;
    logic                 out_stall;
    logic [FLOW_BITS-1:0] max_flow;

    push_relabel_max_flow dut (.*);

    // Predictor state: configuration, capacities and push-relabel scratch
    logic [REG_BITS-1:0] cur_node_count;
    logic [REG_BITS-1:0] cur_source;
    logic [REG_BITS-1:0] cur_sink;
    logic [CAP_BITS-1:0] cap_mem [MEM_DEPTH];
    longint              resid [MEM_DEPTH];
    longint              excess [MAX_NODES];
    int                  height [MAX_NODES];
    bit                  active [MAX_NODES];

    edge_item_t          pending_edges[$];
    logic [FLOW_BITS-1:0] flow_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int edges_taken;
    int answers_seen;
    int cfg_writes;
    int quiet_cycles;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void push_excess(int u, int v, int s, int t);
        longint amount;
        amount = (resid[u*MAX_NODES+v] < excess[u]) ? resid[u*MAX_NODES+v] : excess[u];
        resid[u*MAX_NODES+v] -= amount;
        resid[v*MAX_NODES+u] += amount;
        excess[u] -= amount;
        excess[v] += amount;
        if (excess[u] == 0)
            active[u] = 0;
        if (amount > 0 && v != s && v != t)
            active[v] = 1;
    endfunction

    // Push-relabel over the stored capacities with the current configuration
    function automatic logic [FLOW_BITS-1:0] solve_max_flow();
        int n;
        int s;
        int t;
        int u;
        int low;
        bit found;
        n = int'(cur_node_count);
        if (n < 2)
            n = 2;
        if (n > MAX_NODES)
            n = MAX_NODES;
        if (cur_source < 1 || cur_source > n || cur_sink < 1 || cur_sink > n ||
            cur_source == cur_sink)
            return '0;
        s = int'(cur_source) - 1;
        t = int'(cur_sink) - 1;
        for (int i = 0; i < MEM_DEPTH; i++)
            resid[i] = longint'(cap_mem[i]);
        for (int i = 0; i < MAX_NODES; i++)
        begin
            height[i] = 0;
            excess[i] = 0;
            active[i] = 0;
        end
        height[s] = n;
        // saturate every source edge
        for (int v = 0; v < n; v++)
        begin
            if (v == s)
                continue;
            excess[s] = resid[s*MAX_NODES+v];
            push_excess(s, v, s, t);
        end
        excess[s] = 0;
        // discharge lowest-numbered active node until none is left
        forever
        begin
            found = 0;
            for (u = 0; u < n; u++)
                if (active[u])
                begin
                    found = 1;
                    break;
                end
            if (!found)
                break;
            for (int v = 0; v < n && excess[u] > 0; v++)
                if (v != u && resid[u*MAX_NODES+v] > 0 && height[u] > height[v])
                    push_excess(u, v, s, t);
            if (excess[u] == 0)
            begin
                active[u] = 0;
                continue;
            end
            low = -1;
            for (int v = 0; v < n; v++)
                if (v != u && resid[u*MAX_NODES+v] > 0 && (low < 0 || height[v] < low))
                    low = height[v];
            if (low < 0)
                active[u] = 0;
            else
                height[u] = low + 1;
        end
        return excess[t][FLOW_BITS-1:0];
    endfunction

    // Store an accepted edge; the last one yields an expected answer
    function automatic void take_edge(edge_item_t it);
        if (it.tail >= 1 && it.tail <= MAX_NODES && it.head >= 1 && it.head <= MAX_NODES)
            cap_mem[(it.tail-1)*MAX_NODES + (it.head-1)] = it.cap;
        if (it.last)
        begin
            flow_q.push_back(solve_max_flow());
            for (int i = 0; i < MEM_DEPTH; i++)
                cap_mem[i] = '0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Driver: presents queued edge items
    always @(posedge clk or negedge rst_n)
    begin
        edge_item_t it;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            from_node     <= '0;
            to_node       <= '0;
            edge_capacity <= '0;
            last_edge     <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                it.tail = from_node;
                it.head = to_node;
                it.cap  = edge_capacity;
                it.last = last_edge;
                take_edge(it);
                edges_taken++;
            end
            if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_edges.pop_front();
                from_node     <= it.tail;
                to_node       <= it.head;
                edge_capacity <= it.cap;
                last_edge     <= it.last;
                in_valid      <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: random stall, answer check, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        logic [FLOW_BITS-1:0] want;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (out_valid && !out_stall)
            begin
                answers_seen++;
                if (flow_q.size() == 0)
                    report_mismatch("unexpected answer", max_flow, -1);
                else
                begin
                    want = flow_q.pop_front();
                    if (max_flow !== want)
                        report_mismatch("max_flow", max_flow, want);
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d answers outstanding", flow_q.size());
                $display("push_relabel_max_flow regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_edge(int tail, int head, int cap, bit last);
        edge_item_t it;
        it.tail = REG_BITS'(tail);
        it.head = REG_BITS'(head);
        it.cap  = CAP_BITS'(cap);
        it.last = last;
        pending_edges.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_edges.size() > 0 || in_valid || flow_q.size() > 0)
            @(negedge clk);
    endtask

    // Registers change only once the block is drained and its clearing pass is over
    task automatic set_config(int nc, int src, int snk);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        for (int r = 0; r < 3; r++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            case (r)
                0:
                begin
                    cfg_index <= REG_NODE_COUNT;
                    cfg_data  <= REG_BITS'(nc);
                    cur_node_count = REG_BITS'(nc);
                end
                1:
                begin
                    cfg_index <= REG_SOURCE_NODE;
                    cfg_data  <= REG_BITS'(src);
                    cur_source = REG_BITS'(src);
                end
                default:
                begin
                    cfg_index <= REG_SINK_NODE;
                    cfg_data  <= REG_BITS'(snk);
                    cur_sink = REG_BITS'(snk);
                end
            endcase
            cfg_writes++;
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic int pick_node(int n);
        if ($urandom_range(99) < 12)
            return $urandom_range(127);
        return $urandom_range(n, 1);
    endfunction

    function automatic int pick_cap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom_range(20);
        if (r < 80)
            return $urandom_range(65535);
        return (r < 90) ? 0 : 65535;
    endfunction

    // Stimulus
    initial
    begin
        int rand_edges;
        int nc;
        int neff;
        int src;
        int snk;
        int n_edges;
        int pick;
        cfg_write      = 1'b0;
        cfg_index      = REG_NODE_COUNT;
        cfg_data       = '0;
        cur_node_count = REG_BITS'(MAX_NODES);
        cur_source     = REG_BITS'(1);
        cur_sink       = REG_BITS'(MAX_NODES);
        send_idle_pct  = 35;
        recv_stall_pct = 86;
        errors         = 0;
        edges_taken    = 0;
        answers_seen   = 0;
        cfg_writes     = 0;
        rand_edges     = 0;
        for (int i = 0; i < MEM_DEPTH; i++)
            cap_mem[i] = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset configuration, full-range fields, ignored nodes
        add_edge(1, 2, 0, 0);
        add_edge(1, 2, 40000, 0);        // overwrite of a repeated edge
        add_edge(1, 64, 65535, 0);
        add_edge(2, 3, 30000, 0);
        add_edge(3, 2, 500, 0);          // antiparallel pair
        add_edge(2, 2, 65535, 0);        // self loop
        add_edge(0, 64, 65535, 0);       // out-of-range tail
        add_edge(3, 127, 65535, 0);      // out-of-range head
        add_edge(65, 64, 1234, 0);
        add_edge(3, 64, 65535, 1);
        add_edge(127, 0, 65535, 1);      // last edge ignored, empty graph

        // Node count below range acts as two
        set_config(0, 1, 2);
        add_edge(1, 2, 65535, 0);
        add_edge(1, 3, 100, 0);          // node beyond node count
        add_edge(3, 2, 100, 1);
        set_config(1, 2, 1);
        add_edge(2, 1, 777, 1);
        // Node count above range acts as the maximum
        set_config(127, 64, 1);
        add_edge(64, 1, 65535, 0);
        add_edge(64, 32, 65535, 0);
        add_edge(32, 1, 12345, 1);
        // Bad source and sink
        set_config(8, 0, 3);
        add_edge(1, 3, 50, 1);
        set_config(8, 3, 9);
        add_edge(3, 8, 50, 1);
        set_config(8, 4, 4);
        add_edge(4, 5, 50, 1);

        // Random graphs under random configurations
        while (rand_edges < 1050)
        begin
            wait_idle();
            if (rand_edges < 350)
            begin
                send_idle_pct  = 35;
                recv_stall_pct = 86;
            end
            else if (rand_edges < 700)
            begin
                send_idle_pct  = 86;
                recv_stall_pct = 35;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 12)
                nc = (pick < 3) ? 64 : (pick < 6) ? 2 : (pick < 9) ? 127 : $urandom_range(1);
            else
                nc = $urandom_range(10, 2);
            neff = (nc < 2) ? 2 : (nc > 64) ? 64 : nc;
            if ($urandom_range(99) < 10)
            begin
                src = $urandom_range(127);
                snk = $urandom_range(127);
            end
            else
            begin
                src = $urandom_range(neff, 1);
                snk = $urandom_range(neff - 1, 1);
                if (snk >= src)
                    snk++;
            end
            set_config(nc, src, snk);
            for (int g = 0; g < 3; g++)
            begin
                n_edges = $urandom_range(16, 1);
                for (int e = 0; e < n_edges; e++)
                    add_edge(pick_node(neff), pick_node(neff), pick_cap(), e == n_edges - 1);
                rand_edges += n_edges;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d edge items, %0d flow answers, %0d register writes",
                 edges_taken, answers_seen, cfg_writes);
        if (errors == 0 && flow_q.size() == 0)
            $display("push_relabel_max_flow regression: pass");
        else
            $display("push_relabel_max_flow regression: fail");
        $finish;
    end

endmodule
